// ===== rtl/core/mpfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfr_pkg
// Shared constants and types of the position frame receiver.
// ----------------------------------------------------------------------------
package mpfr_pkg;

  localparam int BUFFER_BYTES = 16;
  localparam int FRAME_LEN    = 9;
  localparam int CRC_LEN      = 7;

  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int IDX_W = $clog2(FRAME_LEN);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  POSITION_BYTES    = 8'h04;

  localparam logic [7:0]  ANGLE_MULT  = 8'd45;
  localparam int          ANGLE_SHIFT = 7;
  localparam logic [14:0] HALF_TURN   = 15'd180;
  localparam logic signed [15:0] FULL_TURN = 16'sd360;

  localparam logic [7:0]  CLAMP_RESET   = 8'd45;
  localparam logic [7:0]  ADDRESS_RESET = 8'd1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT    = 1'd1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_CRC    = 2'd2,
    ST_HEADER = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] position;
    logic        ready;
  } frame_result_t;

endpackage

// ===== rtl/core/mpfr_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfr_rx_if
// Byte channel into the receiver: one received byte and its end mark.
// ----------------------------------------------------------------------------
interface mpfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ===== rtl/core/mpfr_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfr_res_if
// Result channel out of the receiver: frame status and position report.
// ----------------------------------------------------------------------------
interface mpfr_res_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [15:0]       position;
  logic [14:0]       angle;
  logic signed [8:0] clamped_angle;
  logic              ready_res;

  modport source (output valid, output status, output position, output angle,
                  output clamped_angle, output ready_res, input ready);
  modport sink   (input valid, input status, input position, input angle,
                  input clamped_angle, input ready_res, output ready);
endinterface

// ===== rtl/core/mpfr_frame_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfr_frame_check
// Byte counting, CRC-16 accumulation, frame buffer and end-of-frame checks.
// ----------------------------------------------------------------------------
module mpfr_frame_check
  import mpfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          rx_valid,
  output logic          rx_ready,
  input  logic [7:0]    rx_byte,
  input  logic          frame_end,
  input  logic [7:0]    device_address,
  input  logic          take,
  output logic          mid_valid,
  output frame_result_t mid
);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  logic [15:0]    crc_acc;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]     frame_bytes [FRAME_LEN];
  logic [15:0]    held_position;
  logic           seen_valid;

  logic [15:0]    crc_next;
  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]     bytes_next [FRAME_LEN];
  status_t        status_now;
  logic           accept;

  assign rx_ready = !mid_valid || take;
  assign accept   = rx_valid && rx_ready;

  always_comb begin
    crc_next = crc_acc;
    if (byte_count < CNT_W'(CRC_LEN)) begin
      crc_next = crc_byte(crc_acc, rx_byte);
    end
    byte_count_next = byte_count;
    if (byte_count < CNT_W'(BUFFER_BYTES)) begin
      byte_count_next = byte_count + CNT_W'(1);
    end
    for (int i = 0; i < FRAME_LEN; i++) begin
      bytes_next[i] = frame_bytes[i];
    end
    if (byte_count < CNT_W'(FRAME_LEN)) begin
      bytes_next[byte_count[IDX_W-1:0]] = rx_byte;
    end
    if (byte_count_next != CNT_W'(FRAME_LEN)) begin
      status_now = ST_LENGTH;
    end else if (bytes_next[7] != crc_next[7:0] || bytes_next[8] != crc_next[15:8]) begin
      status_now = ST_CRC;
    end else if (bytes_next[0] != device_address || bytes_next[1] != FUNC_READ_HOLDING ||
                 bytes_next[2] != POSITION_BYTES) begin
      status_now = ST_HEADER;
    end else begin
      status_now = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc       <= CRC_INIT;
      byte_count    <= '0;
      held_position <= '0;
      seen_valid    <= 1'b0;
      mid_valid     <= 1'b0;
    end else begin
      if (accept && frame_end) begin
        mid_valid <= 1'b1;
      end else if (take) begin
        mid_valid <= 1'b0;
      end
      if (accept) begin
        if (frame_end) begin
          crc_acc    <= CRC_INIT;
          byte_count <= '0;
          if (status_now == ST_OK) begin
            held_position <= {bytes_next[5], bytes_next[6]};
            seen_valid    <= 1'b1;
          end
        end else begin
          crc_acc    <= crc_next;
          byte_count <= byte_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        frame_bytes[i] <= bytes_next[i];
      end
      if (frame_end) begin
        mid.status <= status_now;
        if (status_now == ST_OK) begin
          mid.position <= {bytes_next[5], bytes_next[6]};
          mid.ready    <= 1'b1;
        end else begin
          mid.position <= held_position;
          mid.ready    <= seen_valid;
        end
      end
    end
  end

endmodule

// ===== rtl/core/mpfr_angle_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfr_angle_out
// Angle scaling, signed wrap and clamp, and the result output register.
// ----------------------------------------------------------------------------
module mpfr_angle_out
  import mpfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          mid_valid,
  input  frame_result_t mid,
  input  logic [7:0]    clamp_limit,
  output logic          take,
  mpfr_res_if.source    res
);

  logic [21:0]        scaled;
  logic [14:0]        angle_now;
  logic signed [15:0] wrapped;
  logic signed [15:0] lim;
  logic signed [15:0] clamped;

  assign take = mid_valid && (!res.valid || res.ready);

  always_comb begin
    scaled    = 22'(mid.position) * 22'(ANGLE_MULT);
    angle_now = scaled[ANGLE_SHIFT +: 15];
    if (angle_now < HALF_TURN) begin
      wrapped = $signed({1'b0, angle_now});
    end else begin
      wrapped = $signed({1'b0, angle_now}) - FULL_TURN;
    end
    lim = $signed({8'h00, clamp_limit});
    if (wrapped > lim) begin
      clamped = lim;
    end else if (wrapped < -lim) begin
      clamped = -lim;
    end else begin
      clamped = wrapped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.status        <= mid.status;
      res.position      <= mid.position;
      res.angle         <= angle_now;
      res.clamped_angle <= clamped[8:0];
      res.ready_res     <= mid.ready;
    end
  end

endmodule

// ===== rtl/core/modbus_position_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_position_frame_receiver
// Checks Modbus position response frames and reports the encoder angle.
//
//   Channel  Role    Payload
//   rx       sink    rx_byte, frame_end
//   res      source  status, position, angle, clamped_angle, ready_res
//   cfg      write   cfg_index, cfg_data (device_address, clamp_limit)
//
// One byte is taken in every cycle while rx.ready is high; the byte update and
// CRC step are combinational. A report is registered in mid at frame end, then
// in the output register. Reset clears the counter, held position and ready
// flag and presets the CRC. A stalled result stalls the byte input only once
// both result stages hold.
module modbus_position_frame_receiver
  import mpfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  mpfr_rx_if.sink              rx,
  mpfr_res_if.source           res
);

  logic [7:0]    device_address;
  logic [7:0]    clamp_limit;
  logic          take;
  logic          mid_valid;
  frame_result_t mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDRESS_RESET;
      clamp_limit    <= CLAMP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEVICE_ADDRESS) begin
        device_address <= cfg_data;
      end else if (cfg_index == CFG_CLAMP_LIMIT) begin
        clamp_limit <= cfg_data;
      end
    end
  end

  mpfr_frame_check u_check (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx.valid),
    .rx_ready       (rx.ready),
    .rx_byte        (rx.rx_byte),
    .frame_end      (rx.frame_end),
    .device_address (device_address),
    .take           (take),
    .mid_valid      (mid_valid),
    .mid            (mid)
  );

  mpfr_angle_out u_angle (
    .clk         (clk),
    .rst         (rst),
    .mid_valid   (mid_valid),
    .mid         (mid),
    .clamp_limit (clamp_limit),
    .take        (take),
    .res         (res)
  );

endmodule

// ===== test/mpfr_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfr_frame_checker
// Watches the byte and report channels of the position frame receiver,
// follows every byte transfer with its own copy of the frame state, and
// compares each report transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mpfr_frame_checker
  import mpfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  mpfr_rx_if                   rx,
  mpfr_res_if                  res,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    status_t           status;
    logic [15:0]       position;
    logic [14:0]       angle;
    logic signed [8:0] clamped;
    logic              ready_res;
  } frame_report_t;

  frame_report_t expected_reports[$];

  logic [7:0]  addr_reg;
  logic [7:0]  limit_reg;
  logic [15:0] crc_run;
  int          byte_cnt;
  logic [7:0]  frame_buf [0:FRAME_LEN-1];
  logic [15:0] held_pos;
  logic        valid_seen;
  int          mismatch_count = 0;

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic void take_byte(input logic [7:0] b, input logic last);
    frame_report_t r;
    logic [31:0]   scaled;
    int            ang;
    int            sang;
    int            lim;
    if (byte_cnt < FRAME_LEN) frame_buf[byte_cnt] = b;
    if (byte_cnt < CRC_LEN) crc_run = crc_next(crc_run, b);
    if (byte_cnt < BUFFER_BYTES) byte_cnt++;
    if (last) begin
      if (byte_cnt != FRAME_LEN) begin
        r.status = ST_LENGTH;
      end else if (frame_buf[7] != crc_run[7:0] || frame_buf[8] != crc_run[15:8]) begin
        r.status = ST_CRC;
      end else if (frame_buf[0] != addr_reg || frame_buf[1] != FUNC_READ_HOLDING ||
                   frame_buf[2] != POSITION_BYTES) begin
        r.status = ST_HEADER;
      end else begin
        r.status   = ST_OK;
        held_pos   = {frame_buf[5], frame_buf[6]};
        valid_seen = 1'b1;
      end
      byte_cnt = 0;
      crc_run  = CRC_INIT;
      scaled = 32'(held_pos) * 32'd360;
      ang    = int'(scaled >> 10);
      sang   = (ang < 180) ? ang : ang - 360;
      lim    = int'(limit_reg);
      if (sang > lim) begin
        sang = lim;
      end else if (sang < -lim) begin
        sang = -lim;
      end
      r.position  = held_pos;
      r.angle     = 15'(ang);
      r.clamped   = 9'(sang);
      r.ready_res = valid_seen;
      expected_reports.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t ns: report mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    frame_report_t want;
    if (rst) begin
      addr_reg   = ADDRESS_RESET;
      limit_reg  = CLAMP_RESET;
      crc_run    = CRC_INIT;
      byte_cnt   = 0;
      held_pos   = '0;
      valid_seen = 1'b0;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEVICE_ADDRESS: begin
            addr_reg = cfg_data;
          end
          CFG_CLAMP_LIMIT: begin
            limit_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (res.valid && res.ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected transfer, status", int'(res.status), -1);
        end else begin
          want = expected_reports.pop_front();
          if (res.status !== want.status)
            report_mismatch("status", int'(res.status), int'(want.status));
          if (res.position !== want.position)
            report_mismatch("position", int'(res.position), int'(want.position));
          if (res.angle !== want.angle)
            report_mismatch("angle", int'(res.angle), int'(want.angle));
          if (res.clamped_angle !== want.clamped)
            report_mismatch("clamped_angle", int'(res.clamped_angle),
                            int'($signed(want.clamped)));
          if (res.ready_res !== want.ready_res)
            report_mismatch("ready_res", int'(res.ready_res), int'(want.ready_res));
        end
      end
      if (rx.valid && rx.ready) take_byte(rx.rx_byte, rx.frame_end);
    end
    errors  <= mismatch_count;
    pending <= expected_reports.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives Modbus position response frames into the receiver: a few directed
// frames, then phases of random well-formed, corrupted, short and long
// frames under several register settings, with random gaps on both sides,
// a long stall of the report side and pauses until all reports are in.
// ----------------------------------------------------------------------------
module tb;
  import mpfr_pkg::*;

  localparam int ITEMS_TOTAL = 1750;
  localparam int NUM_PHASES  = 6;
  localparam int HOLD_PHASE  = 3;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {
    FK_GOOD,
    FK_HEADER,
    FK_CRC,
    FK_LENGTH,
    FK_LONG,
    FK_NOISE
  } frame_kind_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  int         error_count;
  int         pending_count;
  int         cycle_count = 0;
  int         items_sent = 0;
  int         src_max_gap = 6;
  int         sink_max_gap = 6;
  bit         hold_request = 1'b0;
  logic [7:0] dev_addr = ADDRESS_RESET;
  logic [7:0] frame_q[$];

  mpfr_rx_if  rx_ch ();
  mpfr_res_if res_ch ();

  modbus_position_frame_receiver u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .res       (res_ch)
  );

  mpfr_frame_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .res       (res_ch),
    .errors    (error_count),
    .pending   (pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic logic [15:0] frame_crc(input int n);
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      c ^= {8'h00, frame_q[i]};
      for (int k = 0; k < 8; k++) begin
        if (c[0]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] pick_position();
    logic [15:0] corners [10];
    corners = '{16'h0000, 16'h0001, 16'h01FF, 16'h0200, 16'h0201,
                16'h03FF, 16'h0400, 16'h7FFF, 16'h8000, 16'hFFFF};
    case ($urandom_range(0, 3))
      0: return corners[$urandom_range(0, 9)];
      1: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  // Seven header and data bytes; optional header damage comes before the CRC.
  function automatic void build_response(input logic [7:0] addr, input logic [7:0] fn,
                                         input logic [7:0] cnt, input logic [15:0] pos);
    logic [15:0] crc;
    frame_q.delete();
    frame_q.push_back(addr);
    frame_q.push_back(fn);
    frame_q.push_back(cnt);
    frame_q.push_back(8'($urandom));
    frame_q.push_back(8'($urandom));
    frame_q.push_back(pos[15:8]);
    frame_q.push_back(pos[7:0]);
    crc = frame_crc(CRC_LEN);
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FK_GOOD;
    if (r < 65) return FK_HEADER;
    if (r < 75) return FK_CRC;
    if (r < 85) return FK_LENGTH;
    if (r < 92) return FK_LONG;
    return FK_NOISE;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid     <= 1'b1;
    rx_ch.rx_byte   <= b;
    rx_ch.frame_end <= last;
    @(posedge clk);
    while (!(rx_ch.valid && rx_ch.ready)) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  task automatic send_kind(input frame_kind_t kind);
    logic [7:0] hdr [3];
    int         len;
    int         k;
    hdr = '{dev_addr, FUNC_READ_HOLDING, POSITION_BYTES};
    case (kind)
      FK_GOOD: begin
        build_response(hdr[0], hdr[1], hdr[2], pick_position());
      end
      FK_HEADER: begin
        k = $urandom_range(0, 2);
        hdr[k] ^= 8'($urandom_range(1, 255));
        build_response(hdr[0], hdr[1], hdr[2], pick_position());
      end
      FK_CRC: begin
        build_response(hdr[0], hdr[1], hdr[2], pick_position());
        k = $urandom_range(0, FRAME_LEN - 1);
        frame_q[k] ^= 8'(1 << $urandom_range(0, 7));
      end
      FK_LENGTH: begin
        if ($urandom_range(0, 1) == 1) begin
          build_response(hdr[0], hdr[1], hdr[2], pick_position());
          if ($urandom_range(0, 1) == 1) begin
            len = $urandom_range(1, FRAME_LEN - 1);
            while (frame_q.size() > len) void'(frame_q.pop_back());
          end else begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
          end
        end else begin
          len = $urandom_range(1, 14);
          if (len >= FRAME_LEN) len++;
          frame_q.delete();
          repeat (len) frame_q.push_back(8'($urandom));
        end
      end
      FK_LONG: begin
        frame_q.delete();
        repeat ($urandom_range(BUFFER_BYTES, 2 * BUFFER_BYTES)) frame_q.push_back(8'($urandom));
      end
      default: begin
        frame_q.delete();
        repeat (FRAME_LEN) frame_q.push_back(8'($urandom));
      end
    endcase
    send_frame();
  endtask

  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [7:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEVICE_ADDRESS;
    cfg_data  <= addr;
    @(posedge clk);
    cfg_index <= CFG_CLAMP_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    dev_addr = addr;
  endtask

  // Report side: random stalls, plus one long stall on request.
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = hold_request ? LONG_HOLD : $urandom_range(0, sink_max_gap);
      hold_request = 1'b0;
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
    end
  end

  initial begin
    int quota;
    rx_ch.valid     = 1'b0;
    rx_ch.rx_byte   = '0;
    rx_ch.frame_end = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: lone byte before any valid frame, full-scale position that
    // fails its CRC, damaged CRC, and a wrong function code under a good CRC.
    frame_q = '{8'h00};
    send_frame();
    build_response(ADDRESS_RESET, FUNC_READ_HOLDING, POSITION_BYTES, 16'hFFFF);
    frame_q[3] = 8'h00;
    frame_q[4] = 8'hFF;
    send_frame();
    build_response(ADDRESS_RESET, FUNC_READ_HOLDING, POSITION_BYTES, 16'h0200);
    frame_q[8] ^= 8'h80;
    send_frame();
    build_response(ADDRESS_RESET, 8'h06, POSITION_BYTES, 16'h0300);
    send_frame();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: set_config(ADDRESS_RESET, CLAMP_RESET);
        1: set_config(8'h00, 8'd0);
        2: set_config(8'hFF, 8'd180);
        default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 180)));
      endcase
      src_max_gap  = (ph == 1 || ph == 5) ? 0 : 6;
      sink_max_gap = (ph == 2 || ph == 5) ? 0 : 6;
      if (ph == HOLD_PHASE) begin
        hold_request = 1'b1;
        src_max_gap  = 0;
        repeat (60) send_byte(8'($urandom), 1'b1);
        src_max_gap = 6;
      end
      quota = items_sent + ITEMS_TOTAL / NUM_PHASES;
      while (items_sent < quota) send_kind(pick_kind());
    end

    wait_idle();
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
